### hw/rtl/ptrp_pkg.sv
// Shared types and constants of the point transform and raster projection block.
`timescale 1ns / 1ps

package ptrp_pkg;

	typedef enum logic [1:0] {
		OP_LOAD   = 2'd0,
		OP_POINT  = 2'd1,
		OP_DIR    = 2'd2,
		OP_RASTER = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK          = 2'd0,
		ST_W_ZERO      = 2'd1,
		ST_DEPTH_ZERO  = 2'd2,
		ST_CANVAS_ZERO = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_CANVAS_W = 2'd0,
		CFG_CANVAS_H = 2'd1,
		CFG_IMAGE_W  = 2'd2,
		CFG_IMAGE_H  = 2'd3
	} cfg_idx_t;

	localparam int COORD_W     = 32;
	localparam int CANVAS_W    = 31;
	localparam int IMAGE_W     = 16;
	localparam int CFG_DATA_W  = 31;
	localparam int MAT_ENTRIES = 16;

	localparam logic [IMAGE_W-1:0] IMAGE_W_RESET = 16'd640;
	localparam logic [IMAGE_W-1:0] IMAGE_H_RESET = 16'd480;

	typedef struct packed {
		logic signed [COORD_W-1:0] out_x;
		logic signed [COORD_W-1:0] out_y;
		logic signed [COORD_W-1:0] out_z;
		logic signed [COORD_W-1:0] pixel_x;
		logic signed [COORD_W-1:0] pixel_y;
		status_t                   status;
	} res_t;

endpackage

### hw/rtl/ptrp_in_if.sv
// Input channel: operation, matrix element and coordinates with valid/ready.
`timescale 1ns / 1ps

interface ptrp_in_if;
	logic              valid;
	logic              ready;
	logic [1:0]        operation;
	logic [3:0]        element_index;
	logic signed [31:0] element_value;
	logic signed [31:0] in_x;
	logic signed [31:0] in_y;
	logic signed [31:0] in_z;

	modport source (output valid, output operation, output element_index,
		output element_value, output in_x, output in_y, output in_z, input ready);
	modport sink (input valid, input operation, input element_index,
		input element_value, input in_x, input in_y, input in_z, output ready);
endinterface

### hw/rtl/ptrp_out_if.sv
// Result channel: transformed coordinates, pixel position and status with valid/ready.
`timescale 1ns / 1ps

interface ptrp_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] out_x;
	logic signed [31:0] out_y;
	logic signed [31:0] out_z;
	logic signed [31:0] pixel_x;
	logic signed [31:0] pixel_y;
	logic [1:0]         status;

	modport source (output valid, output out_x, output out_y, output out_z,
		output pixel_x, output pixel_y, output status, input ready);
	modport sink (input valid, input out_x, input out_y, input out_z,
		input pixel_x, input pixel_y, input status, output ready);
endinterface

### hw/rtl/ptrp_lane.sv
// One column lane: three products floored to the fraction and summed, with translation when with_t is set.
`timescale 1ns / 1ps

module ptrp_lane #(
	parameter int FRAC_BITS = 16
) (
	input  logic                        clk,
	input  logic                        en,
	input  logic signed [31:0]          x,
	input  logic signed [31:0]          y,
	input  logic signed [31:0]          z,
	input  logic signed [31:0]          e0,
	input  logic signed [31:0]          e1,
	input  logic signed [31:0]          e2,
	input  logic signed [31:0]          e3,
	input  logic                        with_t,
	output logic signed [65-FRAC_BITS:0] dot
);
	localparam int DOT_W = 66 - FRAC_BITS;

	logic signed [63:0] px_s1, py_s1, pz_s1;
	logic signed [31:0] t_s1;
	logic signed [DOT_W-1:0] dot_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= x * e0;
			py_s1 <= y * e1;
			pz_s1 <= z * e2;
			t_s1  <= with_t ? e3 : 32'sd0;
		end
	end

	// arithmetic shift floors each product
	always_ff @(posedge clk) begin
		if (en) begin
			dot_s2 <= DOT_W'(px_s1 >>> FRAC_BITS) + DOT_W'(py_s1 >>> FRAC_BITS)
				+ DOT_W'(pz_s1 >>> FRAC_BITS) + DOT_W'(t_s1);
		end
	end

	assign dot = dot_s2;
endmodule

### hw/rtl/ptrp_div.sv
// Pipelined restoring divider, one quotient bit a stage, truncated and saturated.
`timescale 1ns / 1ps

module ptrp_div #(
	parameter int NUM_W = 50,
	parameter int DEN_W = 50,
	parameter int SHIFT = 16,
	parameter int SAT_W = 32,
	parameter int TAG_W = 1
) (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [NUM_W-1:0] num,
	input  logic signed [DEN_W-1:0] den,
	input  logic [TAG_W-1:0]        tag_in,
	output logic signed [SAT_W-1:0] quo,
	output logic [TAG_W-1:0]        tag_out
);
	localparam int QW  = SAT_W + 1;
	localparam int N_W = NUM_W + SHIFT;
	localparam int T_W = DEN_W + QW;
	localparam int CW  = (N_W > T_W) ? N_W : T_W;
	localparam logic [QW-1:0] LIM = (QW'(1) << (SAT_W - 1)) - QW'(1);

	logic [NUM_W-1:0] an;
	logic [DEN_W-1:0] ad;
	logic [CW-1:0]    n_ext, t_ext;

	logic [CW-1:0]    rem_q [0:QW];
	logic [DEN_W-1:0] ad_q  [0:QW];
	logic [QW-1:0]    q_q   [0:QW];
	logic             neg_q [0:QW];
	logic             ovf_q [0:QW];
	logic [TAG_W-1:0] tag_q [0:QW];

	logic signed [SAT_W-1:0] quo_q;
	logic [TAG_W-1:0]        tag_o_q;

	assign an    = num[NUM_W-1] ? (~$unsigned(num) + NUM_W'(1)) : $unsigned(num);
	assign ad    = den[DEN_W-1] ? (~$unsigned(den) + DEN_W'(1)) : $unsigned(den);
	assign n_ext = CW'(an) << SHIFT;
	assign t_ext = CW'(ad) << QW;

	// quotient too large for the bits computed: flag and saturate later
	always_ff @(posedge clk) begin
		if (en) begin
			rem_q[0] <= n_ext;
			ad_q[0]  <= ad;
			q_q[0]   <= '0;
			neg_q[0] <= num[NUM_W-1] ^ den[DEN_W-1];
			ovf_q[0] <= n_ext >= t_ext;
			tag_q[0] <= tag_in;
		end
	end

	for (genvar i = 1; i <= QW; i++) begin : g_bit
		localparam int B = QW - i;
		logic [CW-1:0] trial;
		logic          ge;

		assign trial = CW'(ad_q[i-1]) << B;
		assign ge    = rem_q[i-1] >= trial;

		always_ff @(posedge clk) begin
			if (en) begin
				rem_q[i] <= ge ? (rem_q[i-1] - trial) : rem_q[i-1];
				ad_q[i]  <= ad_q[i-1];
				q_q[i]   <= q_q[i-1] | (QW'(ge) << B);
				neg_q[i] <= neg_q[i-1];
				ovf_q[i] <= ovf_q[i-1];
				tag_q[i] <= tag_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			tag_o_q <= tag_q[QW];
			if (neg_q[QW]) begin
				if (ovf_q[QW] || q_q[QW] > LIM + QW'(1)) begin
					quo_q <= {1'b1, {(SAT_W-1){1'b0}}};
				end else begin
					quo_q <= SAT_W'(~q_q[QW] + QW'(1));
				end
			end else begin
				if (ovf_q[QW] || q_q[QW] > LIM) begin
					quo_q <= {1'b0, {(SAT_W-1){1'b1}}};
				end else begin
					quo_q <= SAT_W'(q_q[QW]);
				end
			end
		end
	end

	assign quo     = quo_q;
	assign tag_out = tag_o_q;
endmodule

### hw/rtl/point_transform_raster_projection.sv
// Top level: matrix store, column lanes, divider chain and output skid stage.
`timescale 1ns / 1ps

// Takes one item per cycle, loads included, while the skid entry is empty. A load writes
// its matrix element at the transfer and gives no result; every other item gives one
// result. Its path runs through three chained dividers, each S+3 stages deep (one quotient
// bit a stage), where S = min(COORD_WIDTH, 32): x, y, z by w, screen x and y by minus
// depth, then the pixel mapping. Four column lanes form the dot products in parallel.
// The output register has one skid entry behind it, so the input keeps taking items
// while a result waits; it holds off only when both are full.
// The matrix resets to identity; configuration is read live and must stay stable while
// items are in flight.
module point_transform_raster_projection #(
	parameter int FRAC_BITS   = 16,
	parameter int COORD_WIDTH = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	ptrp_in_if.sink     points,
	ptrp_out_if.source  results,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [30:0] wr_data
);
	localparam int SAT_W  = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
	localparam int DOT_W  = 66 - FRAC_BITS;
	localparam int QW     = SAT_W + 1;
	localparam int DIV_L  = QW + 2;
	localparam int VL     = 4 + 3 * DIV_L;
	localparam int SUM_W  = ((SAT_W + 1 > 32) ? SAT_W + 1 : 32) + 1;
	localparam int PN_W   = SUM_W + 17;
	localparam int TAG1_W = SAT_W + 3;
	localparam int TAG2_W = 2 * SAT_W + 3;
	localparam longint SAT_MAX = (64'sd1 <<< (SAT_W - 1)) - 64'sd1;
	localparam longint SAT_MIN = -SAT_MAX - 64'sd1;

	function automatic logic signed [SAT_W-1:0] sat_dot(input logic signed [DOT_W-1:0] v);
		logic signed [DOT_W-1:0] hi, lo;
		hi = DOT_W'(SAT_MAX);
		lo = DOT_W'(SAT_MIN);
		if (v > hi) return SAT_W'(hi);
		if (v < lo) return SAT_W'(lo);
		return SAT_W'(v);
	endfunction

	logic signed [31:0] mat_q [ptrp_pkg::MAT_ENTRIES];
	logic [ptrp_pkg::CANVAS_W-1:0] cw_q, ch_q;
	logic [ptrp_pkg::IMAGE_W-1:0]  iw_q, ih_q;

	logic out_vld_q, skid_vld_q, pop;
	logic en, acc;
	logic vld_q [0:VL];

	logic signed [31:0] x_s0, y_s0, z_s0;
	ptrp_pkg::op_t      op_s0, op_s1, op_s2;
	logic signed [DOT_W-1:0] dot [4];

	assign en  = !skid_vld_q;
	assign acc = points.valid && en;
	assign points.ready = en;

	// matrix store and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < ptrp_pkg::MAT_ENTRIES; i++) begin
				mat_q[i] <= (i % 5 == 0) ? 32'(64'd1 << FRAC_BITS) : 32'sd0;
			end
		end else if (acc && ptrp_pkg::op_t'(points.operation) == ptrp_pkg::OP_LOAD) begin
			mat_q[points.element_index] <= points.element_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cw_q <= ptrp_pkg::CANVAS_W'(64'd2 << FRAC_BITS);
			ch_q <= ptrp_pkg::CANVAS_W'(64'd2 << FRAC_BITS);
			iw_q <= ptrp_pkg::IMAGE_W_RESET;
			ih_q <= ptrp_pkg::IMAGE_H_RESET;
		end else if (wr_en) begin
			unique case (ptrp_pkg::cfg_idx_t'(wr_index))
				ptrp_pkg::CFG_CANVAS_W: cw_q <= wr_data;
				ptrp_pkg::CFG_CANVAS_H: ch_q <= wr_data;
				ptrp_pkg::CFG_IMAGE_W:  iw_q <= wr_data[ptrp_pkg::IMAGE_W-1:0];
				ptrp_pkg::CFG_IMAGE_H:  ih_q <= wr_data[ptrp_pkg::IMAGE_W-1:0];
				default: ;
			endcase
		end
	end

	// valid line; loads never enter it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q[0] <= 1'b0;
		end else if (en) begin
			vld_q[0] <= acc && ptrp_pkg::op_t'(points.operation) != ptrp_pkg::OP_LOAD;
		end
	end

	for (genvar i = 1; i <= VL; i++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[i] <= 1'b0;
			end else if (en) begin
				vld_q[i] <= vld_q[i-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s0  <= points.in_x;
			y_s0  <= points.in_y;
			z_s0  <= points.in_z;
			op_s0 <= ptrp_pkg::op_t'(points.operation);
			op_s1 <= op_s0;
			op_s2 <= op_s1;
		end
	end

	for (genvar c = 0; c < 4; c++) begin : g_lane
		ptrp_lane #(.FRAC_BITS(FRAC_BITS)) u_lane (
			.clk    (clk),
			.en     (en),
			.x      (x_s0),
			.y      (y_s0),
			.z      (z_s0),
			.e0     (mat_q[c]),
			.e1     (mat_q[4 + c]),
			.e2     (mat_q[8 + c]),
			.e3     (mat_q[12 + c]),
			.with_t (op_s0 != ptrp_pkg::OP_DIR),
			.dot    (dot[c])
		);
	end

	// x, y, z by w
	logic signed [SAT_W-1:0] qa, qb, qc;
	logic [TAG1_W-1:0] tag_a, tag_a_o;
	logic signed [SAT_W-1:0] tag_b_o, tag_c_o;

	assign tag_a = {op_s2, dot[3] == '0, sat_dot(dot[0])};

	ptrp_div #(.NUM_W(DOT_W), .DEN_W(DOT_W), .SHIFT(FRAC_BITS), .SAT_W(SAT_W),
		.TAG_W(TAG1_W)) u_div_a (
		.clk(clk), .en(en), .num(dot[0]), .den(dot[3]), .tag_in(tag_a),
		.quo(qa), .tag_out(tag_a_o));

	ptrp_div #(.NUM_W(DOT_W), .DEN_W(DOT_W), .SHIFT(FRAC_BITS), .SAT_W(SAT_W),
		.TAG_W(SAT_W)) u_div_b (
		.clk(clk), .en(en), .num(dot[1]), .den(dot[3]), .tag_in(sat_dot(dot[1])),
		.quo(qb), .tag_out(tag_b_o));

	ptrp_div #(.NUM_W(DOT_W), .DEN_W(DOT_W), .SHIFT(FRAC_BITS), .SAT_W(SAT_W),
		.TAG_W(SAT_W)) u_div_c (
		.clk(clk), .en(en), .num(dot[2]), .den(dot[3]), .tag_in(sat_dot(dot[2])),
		.quo(qc), .tag_out(tag_c_o));

	// merge: a direction keeps the saturated sums, a point takes the quotients
	logic signed [SAT_W-1:0] vx_r1, vy_r1, vz_r1;
	ptrp_pkg::op_t op_r1;
	logic          wz_r1;
	ptrp_pkg::op_t op_d1;

	assign op_d1 = ptrp_pkg::op_t'(tag_a_o[TAG1_W-1 -: 2]);

	always_ff @(posedge clk) begin
		if (en) begin
			op_r1 <= op_d1;
			wz_r1 <= tag_a_o[SAT_W];
			vx_r1 <= (op_d1 == ptrp_pkg::OP_DIR) ? tag_a_o[SAT_W-1:0] : qa;
			vy_r1 <= (op_d1 == ptrp_pkg::OP_DIR) ? tag_b_o : qb;
			vz_r1 <= (op_d1 == ptrp_pkg::OP_DIR) ? tag_c_o : qc;
		end
	end

	// screen coordinates: x and y by minus depth
	logic signed [SAT_W:0] nz;
	logic signed [SAT_W-1:0] sx, sy, tag_sy_o;
	logic [TAG2_W-1:0] tag_sx_o;

	assign nz = -(SAT_W + 1)'(vz_r1);

	ptrp_div #(.NUM_W(SAT_W), .DEN_W(SAT_W + 1), .SHIFT(FRAC_BITS), .SAT_W(SAT_W),
		.TAG_W(TAG2_W)) u_div_sx (
		.clk(clk), .en(en), .num(vx_r1), .den(nz),
		.tag_in({op_r1, wz_r1, vx_r1, vz_r1}), .quo(sx), .tag_out(tag_sx_o));

	ptrp_div #(.NUM_W(SAT_W), .DEN_W(SAT_W + 1), .SHIFT(FRAC_BITS), .SAT_W(SAT_W),
		.TAG_W(SAT_W)) u_div_sy (
		.clk(clk), .en(en), .num(vy_r1), .den(nz),
		.tag_in(vy_r1), .quo(sy), .tag_out(tag_sy_o));

	// pixel numerators
	logic signed [SUM_W-1:0] sum_x, sum_y;
	logic signed [PN_W-1:0]  nx_m, ny_m;
	logic [TAG2_W-1:0]       tag_m;
	logic signed [SAT_W-1:0] vy_m;

	assign sum_x = (SUM_W'(sx) <<< 1) + SUM_W'($signed({1'b0, cw_q}));
	assign sum_y = SUM_W'($signed({1'b0, ch_q})) - (SUM_W'(sy) <<< 1);

	always_ff @(posedge clk) begin
		if (en) begin
			nx_m  <= PN_W'(sum_x) * PN_W'($signed({1'b0, iw_q}));
			ny_m  <= PN_W'(sum_y) * PN_W'($signed({1'b0, ih_q}));
			tag_m <= tag_sx_o;
			vy_m  <= tag_sy_o;
		end
	end

	logic signed [SAT_W-1:0] pxq, pyq, vy_f;
	logic [TAG2_W-1:0] tag_f;

	ptrp_div #(.NUM_W(PN_W), .DEN_W(33), .SHIFT(0), .SAT_W(SAT_W),
		.TAG_W(TAG2_W)) u_div_px (
		.clk(clk), .en(en), .num(nx_m), .den($signed({1'b0, cw_q, 1'b0})),
		.tag_in(tag_m), .quo(pxq), .tag_out(tag_f));

	ptrp_div #(.NUM_W(PN_W), .DEN_W(33), .SHIFT(0), .SAT_W(SAT_W),
		.TAG_W(SAT_W)) u_div_py (
		.clk(clk), .en(en), .num(ny_m), .den($signed({1'b0, ch_q, 1'b0})),
		.tag_in(vy_m), .quo(pyq), .tag_out(vy_f));

	// final status and zeroing; canvas size is checked first
	ptrp_pkg::op_t op_f;
	logic          wz_f;
	logic signed [SAT_W-1:0] vx_f, vz_f;
	ptrp_pkg::res_t fin;

	assign op_f = ptrp_pkg::op_t'(tag_f[TAG2_W-1 -: 2]);
	assign wz_f = tag_f[2 * SAT_W];
	assign vx_f = tag_f[2 * SAT_W - 1 -: SAT_W];
	assign vz_f = tag_f[SAT_W-1:0];

	always_comb begin
		fin = '0;
		priority if (op_f == ptrp_pkg::OP_RASTER && (cw_q == '0 || ch_q == '0)) begin
			fin.status = ptrp_pkg::ST_CANVAS_ZERO;
		end else if (op_f != ptrp_pkg::OP_DIR && wz_f) begin
			fin.status = ptrp_pkg::ST_W_ZERO;
		end else if (op_f == ptrp_pkg::OP_RASTER && vz_f == '0) begin
			fin.status = ptrp_pkg::ST_DEPTH_ZERO;
		end else begin
			fin.status = ptrp_pkg::ST_OK;
			fin.out_x  = 32'(vx_f);
			fin.out_y  = 32'(vy_f);
			fin.out_z  = 32'(vz_f);
			if (op_f == ptrp_pkg::OP_RASTER) begin
				fin.pixel_x = 32'(pxq);
				fin.pixel_y = 32'(pyq);
			end
		end
	end

	// output register with one skid entry
	ptrp_pkg::res_t out_q, skid_q;

	assign pop = out_vld_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q  <= 1'b0;
			skid_vld_q <= 1'b0;
		end else if (!out_vld_q || pop) begin
			if (skid_vld_q) begin
				out_vld_q  <= 1'b1;
				skid_vld_q <= 1'b0;
			end else begin
				out_vld_q <= vld_q[VL];
			end
		end else if (en && vld_q[VL]) begin
			skid_vld_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (!out_vld_q || pop) begin
			out_q <= skid_vld_q ? skid_q : fin;
		end else if (en && vld_q[VL]) begin
			skid_q <= fin;
		end
	end

	assign results.valid   = out_vld_q;
	assign results.out_x   = out_q.out_x;
	assign results.out_y   = out_q.out_y;
	assign results.out_z   = out_q.out_z;
	assign results.pixel_x = out_q.pixel_x;
	assign results.pixel_y = out_q.pixel_y;
	assign results.status  = out_q.status;
endmodule

### tb/sv/testbench.sv
// Self-checking testbench for the point transform and raster projection block.
`timescale 1ns / 1ps

module testbench;

	localparam int  FRAC        = 16;
	localparam longint Q_MAX    = 64'sd2147483647;
	localparam longint Q_MIN    = -64'sd2147483648;
	localparam int  STALL_LIMIT = 5000;
	localparam int  DRAIN_WAIT  = 150;
	localparam int  HOLD_CYCLES = 400;

	class projection_scoreboard;
		logic [31:0]      matrix [ptrp_pkg::MAT_ENTRIES];
		longint           canvas_w, canvas_h, image_w, image_h;
		ptrp_pkg::res_t   pending [$];
		int               errors;

		function new();
			for (int i = 0; i < ptrp_pkg::MAT_ENTRIES; i++)
				matrix[i] = (i % 5 == 0) ? 32'h0001_0000 : 32'h0;
			canvas_w = 2 << FRAC;
			canvas_h = 2 << FRAC;
			image_w  = 640;
			image_h  = 480;
			errors   = 0;
		endfunction

		function void set_reg(ptrp_pkg::cfg_idx_t idx, logic [30:0] data);
			case (idx)
				ptrp_pkg::CFG_CANVAS_W: canvas_w = longint'(data);
				ptrp_pkg::CFG_CANVAS_H: canvas_h = longint'(data);
				ptrp_pkg::CFG_IMAGE_W:  image_w  = longint'(data[15:0]);
				ptrp_pkg::CFG_IMAGE_H:  image_h  = longint'(data[15:0]);
			endcase
		endfunction

		function longint sat32(longint v);
			if (v > Q_MAX) return Q_MAX;
			if (v < Q_MIN) return Q_MIN;
			return v;
		endfunction

		function longint coef(int r, int c);
			logic signed [31:0] e;
			e = matrix[r * 4 + c];
			return longint'(e);
		endfunction

		function longint column_sum(longint p [3], int col, bit with_t);
			longint s;
			s = 0;
			for (int i = 0; i < 3; i++)
				s += (p[i] * coef(i, col)) >>> FRAC;
			if (with_t)
				s += coef(3, col);
			return s;
		endfunction

		function longint qdiv(longint num, longint den);
			bit neg;
			longint unsigned an, ad, q, rem;
			neg = (num < 0) != (den < 0);
			an  = (num < 0) ? -num : num;
			ad  = (den < 0) ? -den : den;
			q   = an / ad;
			rem = an % ad;
			if (q > 64'hFFFF_FFFF)
				return neg ? Q_MIN : Q_MAX;
			for (int k = 0; k < FRAC; k++) begin
				rem = rem << 1;
				q   = q << 1;
				if (rem >= ad) begin
					rem = rem - ad;
					q   = q | 1;
				end
			end
			if (neg) begin
				if (q > 64'h8000_0000)
					return Q_MIN;
				return -longint'(q);
			end
			if (q > 64'h7FFF_FFFF)
				return Q_MAX;
			return longint'(q);
		endfunction

		function void note_input(ptrp_pkg::op_t op, logic [3:0] idx,
				logic signed [31:0] val, logic signed [31:0] x, logic signed [31:0] y,
				logic signed [31:0] z);
			longint p [3];
			longint a, b, c, w, cx, cy, cz, sx, sy;
			ptrp_pkg::res_t r;
			if (op == ptrp_pkg::OP_LOAD) begin
				matrix[idx] = val;
				return;
			end
			r = '0;
			r.status = ptrp_pkg::ST_OK;
			p[0] = longint'(x);
			p[1] = longint'(y);
			p[2] = longint'(z);
			if (op == ptrp_pkg::OP_DIR) begin
				r.out_x = 32'(sat32(column_sum(p, 0, 0)));
				r.out_y = 32'(sat32(column_sum(p, 1, 0)));
				r.out_z = 32'(sat32(column_sum(p, 2, 0)));
			end else if (op == ptrp_pkg::OP_RASTER && (canvas_w == 0 || canvas_h == 0)) begin
				r.status = ptrp_pkg::ST_CANVAS_ZERO;
			end else begin
				a = column_sum(p, 0, 1);
				b = column_sum(p, 1, 1);
				c = column_sum(p, 2, 1);
				w = column_sum(p, 3, 1);
				if (w == 0) begin
					r.status = ptrp_pkg::ST_W_ZERO;
				end else begin
					cx = qdiv(a, w);
					cy = qdiv(b, w);
					cz = qdiv(c, w);
					if (op == ptrp_pkg::OP_POINT) begin
						r.out_x = 32'(cx);
						r.out_y = 32'(cy);
						r.out_z = 32'(cz);
					end else if (cz == 0) begin
						r.status = ptrp_pkg::ST_DEPTH_ZERO;
					end else begin
						sx = qdiv(cx, -cz);
						sy = qdiv(cy, -cz);
						r.out_x   = 32'(cx);
						r.out_y   = 32'(cy);
						r.out_z   = 32'(cz);
						r.pixel_x = 32'(sat32(((2 * sx + canvas_w) * image_w)
							/ (2 * canvas_w)));
						r.pixel_y = 32'(sat32(((canvas_h - 2 * sy) * image_h)
							/ (2 * canvas_h)));
					end
				end
			end
			pending.push_back(r);
		endfunction

		function void check_result(ptrp_pkg::res_t got);
			ptrp_pkg::res_t e;
			if (pending.size() == 0) begin
				$display("%0t: unexpected result %h", $time, got);
				errors++;
				return;
			end
			e = pending.pop_front();
			if (got.out_x !== e.out_x) begin
				$display("%0t: out_x expected %h actual %h", $time, e.out_x, got.out_x);
				errors++;
			end
			if (got.out_y !== e.out_y) begin
				$display("%0t: out_y expected %h actual %h", $time, e.out_y, got.out_y);
				errors++;
			end
			if (got.out_z !== e.out_z) begin
				$display("%0t: out_z expected %h actual %h", $time, e.out_z, got.out_z);
				errors++;
			end
			if (got.pixel_x !== e.pixel_x) begin
				$display("%0t: pixel_x expected %h actual %h", $time, e.pixel_x, got.pixel_x);
				errors++;
			end
			if (got.pixel_y !== e.pixel_y) begin
				$display("%0t: pixel_y expected %h actual %h", $time, e.pixel_y, got.pixel_y);
				errors++;
			end
			if (got.status !== e.status) begin
				$display("%0t: status expected %0d actual %0d", $time, e.status, got.status);
				errors++;
			end
		endfunction
	endclass

	logic               clk;
	logic               arst_n;
	logic               wr_en;
	ptrp_pkg::cfg_idx_t wr_index;
	logic [30:0]        wr_data;

	ptrp_in_if  points ();
	ptrp_out_if results ();

	point_transform_raster_projection u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.points   (points),
		.results  (results),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data)
	);

	projection_scoreboard sb;
	int send_idle;
	int recv_idle;
	bit hold_req;
	int hold_cnt;
	int stall_cnt;

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// Note every input transfer in order, so loads land before later items.
	always @(posedge clk) begin
		if (arst_n && points.valid && points.ready)
			sb.note_input(ptrp_pkg::op_t'(points.operation), points.element_index,
				points.element_value, points.in_x, points.in_y, points.in_z);
	end

	always @(posedge clk) begin
		ptrp_pkg::res_t got;
		if (arst_n && results.valid && results.ready) begin
			got.out_x   = results.out_x;
			got.out_y   = results.out_y;
			got.out_z   = results.out_z;
			got.pixel_x = results.pixel_x;
			got.pixel_y = results.pixel_y;
			got.status  = ptrp_pkg::status_t'(results.status);
			sb.check_result(got);
		end
	end

	// Receiver: random stalls, plus one long hold-off to back up the pipeline.
	always @(posedge clk) begin
		if (hold_cnt > 0) begin
			results.ready <= 1'b0;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_req) begin
			results.ready <= 1'b0;
			hold_cnt <= HOLD_CYCLES;
			hold_req <= 1'b0;
		end else begin
			results.ready <= ($urandom_range(0, 99) >= recv_idle);
		end
	end

	always @(posedge clk) begin
		if ((points.valid && points.ready) || (results.valid && results.ready) || wr_en)
			stall_cnt <= 0;
		else
			stall_cnt <= stall_cnt + 1;
		if (stall_cnt >= STALL_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// Ready only changes at the rising edge, so sample it mid-cycle.
	task automatic send_item(ptrp_pkg::op_t op, logic [3:0] idx, logic [31:0] val,
			logic [31:0] x, logic [31:0] y, logic [31:0] z);
		bit took;
		while ($urandom_range(0, 99) < send_idle) begin
			points.valid <= 1'b0;
			@(posedge clk);
		end
		points.valid         <= 1'b1;
		points.operation     <= op;
		points.element_index <= idx;
		points.element_value <= val;
		points.in_x          <= x;
		points.in_y          <= y;
		points.in_z          <= z;
		do begin
			@(negedge clk);
			took = points.ready;
			@(posedge clk);
		end while (!took);
	endtask

	task automatic drain();
		points.valid <= 1'b0;
		@(posedge clk);
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic write_reg(ptrp_pkg::cfg_idx_t idx, logic [30:0] data);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= data;
		@(posedge clk);
		wr_en    <= 1'b0;
		sb.set_reg(idx, data);
	endtask

	function automatic logic [31:0] rand_coord();
		case ($urandom_range(0, 7))
			0, 1:    return $urandom;
			2: begin
				case ($urandom_range(0, 4))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0;
					3: return 32'h1;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			3, 4:    return $urandom_range(0, 32'h7_FFFF) - 32'h4_0000;
			default: return $urandom_range(0, 32'h3F_FFFF) - 32'h20_0000;
		endcase
	endfunction

	// Mostly plausible matrices (a few units, small translation), some noise.
	function automatic logic [31:0] rand_element(logic [3:0] idx);
		if ($urandom_range(0, 9) < 2)
			return rand_coord();
		if (idx[1:0] == 2'd3)
			return (idx == 4'd15) ? $urandom_range(0, 32'h2_0000)
				: $urandom_range(0, 32'h2_0000) - 32'h1_0000;
		return $urandom_range(0, 32'h8_0000) - 32'h4_0000;
	endfunction

	task automatic run_random(int n);
		ptrp_pkg::op_t op;
		logic [3:0]    idx;
		for (int i = 0; i < n; i++) begin
			op  = ptrp_pkg::op_t'($urandom_range(0, 3));
			if (op == ptrp_pkg::OP_LOAD && $urandom_range(0, 2) != 0)
				op = ptrp_pkg::OP_RASTER;
			idx = $urandom_range(0, 15);
			send_item(op, idx, rand_element(idx), rand_coord(), rand_coord(),
				(op == ptrp_pkg::OP_RASTER && $urandom_range(0, 1))
				? -$urandom_range(1, 32'h40_0000) : rand_coord());
		end
	endtask

	initial begin
		sb            = new();
		send_idle     = 0;
		recv_idle     = 0;
		hold_req      = 1'b0;
		hold_cnt      = 0;
		stall_cnt     = 0;
		arst_n        = 1'b0;
		wr_en         = 1'b0;
		wr_index      = ptrp_pkg::CFG_CANVAS_W;
		wr_data       = '0;
		points.valid  = 1'b0;
		points.operation     = ptrp_pkg::OP_LOAD;
		points.element_index = '0;
		points.element_value = '0;
		points.in_x   = '0;
		points.in_y   = '0;
		points.in_z   = '0;
		results.ready = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_item(ptrp_pkg::OP_POINT,  0, 0, 0, 0, 0);
		send_item(ptrp_pkg::OP_POINT,  0, 0, 32'h7FFF_FFFF, 32'h8000_0000, 32'h1);
		send_item(ptrp_pkg::OP_DIR,    0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		send_item(ptrp_pkg::OP_RASTER, 0, 0, 32'h1_0000, 32'h1_0000, 32'hFFFE_0000);
		send_item(ptrp_pkg::OP_RASTER, 0, 0, 32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF);
		// Zero depth
		send_item(ptrp_pkg::OP_RASTER, 0, 0, 32'h1_0000, 32'h2_0000, 32'h0);
		// Zero w: clear the homogeneous corner
		send_item(ptrp_pkg::OP_LOAD,   4'd15, 32'h0, 0, 0, 0);
		send_item(ptrp_pkg::OP_POINT,  0, 0, 32'h5_0000, 32'h3_0000, 32'h7_0000);
		send_item(ptrp_pkg::OP_RASTER, 0, 0, 32'h5_0000, 32'h3_0000, 32'hFFFF_0000);
		send_item(ptrp_pkg::OP_DIR,    0, 0, 32'h5_0000, 32'h3_0000, 32'h7_0000);
		send_item(ptrp_pkg::OP_LOAD,   4'd15, 32'h1_0000, 0, 0, 0);
		// Huge translation saturates the quotient
		send_item(ptrp_pkg::OP_LOAD,   4'd14, 32'h7FFF_FFFF, 0, 0, 0);
		send_item(ptrp_pkg::OP_LOAD,   4'd15, 32'h1, 0, 0, 0);
		send_item(ptrp_pkg::OP_POINT,  0, 0, 32'h1, 32'h1, 32'h1);
		send_item(ptrp_pkg::OP_RASTER, 0, 0, 32'h1, 32'h1, 32'h1);
		send_item(ptrp_pkg::OP_LOAD,   4'd14, 32'h0, 0, 0, 0);
		send_item(ptrp_pkg::OP_LOAD,   4'd15, 32'h1_0000, 0, 0, 0);
		send_item(ptrp_pkg::OP_LOAD,   4'd0, 32'h8000_0000, 0, 0, 0);
		send_item(ptrp_pkg::OP_DIR,    0, 0, 32'h8000_0000, 32'h0, 32'h0);
		send_item(ptrp_pkg::OP_POINT,  0, 0, 32'h8000_0000, 32'h0, 32'h0);
		send_item(ptrp_pkg::OP_LOAD,   4'd0, 32'h1_0000, 0, 0, 0);
		drain();

		for (int phase = 0; phase < 6; phase++) begin
			case (phase)
				1: begin
					write_reg(ptrp_pkg::CFG_CANVAS_W, 31'h7FFF_FFFF);
					write_reg(ptrp_pkg::CFG_CANVAS_H, 31'h7FFF_FFFF);
					write_reg(ptrp_pkg::CFG_IMAGE_W, 31'hFFFF);
					write_reg(ptrp_pkg::CFG_IMAGE_H, 31'hFFFF);
				end
				2: begin
					write_reg(ptrp_pkg::CFG_CANVAS_W, 31'h1);
					write_reg(ptrp_pkg::CFG_CANVAS_H, 31'h1);
					write_reg(ptrp_pkg::CFG_IMAGE_W, 31'h0);
					write_reg(ptrp_pkg::CFG_IMAGE_H, 31'h0);
				end
				3: begin
					write_reg(ptrp_pkg::CFG_CANVAS_W, $urandom_range(1, 31'h8_0000));
					write_reg(ptrp_pkg::CFG_CANVAS_H, $urandom_range(1, 31'h8_0000));
					write_reg(ptrp_pkg::CFG_IMAGE_W, $urandom_range(1, 4096));
					write_reg(ptrp_pkg::CFG_IMAGE_H, $urandom_range(1, 4096));
				end
				4: write_reg(ptrp_pkg::CFG_CANVAS_W, 31'h0);
				5: begin
					write_reg(ptrp_pkg::CFG_CANVAS_W, 31'h2_0000);
					write_reg(ptrp_pkg::CFG_CANVAS_H, 31'h0);
				end
				default: ;
			endcase
			send_idle = (phase < 2) ? 16 : (phase < 4) ? 75 : 0;
			recv_idle = (phase < 2) ? 75 : (phase < 4) ? 16 : 0;
			if (phase == 4)
				hold_req = 1'b1;
			run_random(phase == 5 ? 300 : 340);
			drain();
		end

		if (sb.errors == 0 && sb.pending.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
